@@ src/fti_pkg.sv @@
// Shared types and constants for the frequency table interpolator.
package fti_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int FREQ_W = 32;
	localparam int VAL_W = 16;
	localparam int POINT_W = 8 * VAL_W;
	// Rounded dividend: magnitude of a 33 by 17 bit product plus half the divisor.
	localparam int DIV_W = 51;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_RD_OTHER,
		ST_GOT_OTHER,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

@@ src/fti_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module fti_ram
	import fti_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = MAX_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/fti_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module fti_divider
	import fti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [FREQ_W-1:0] divisor,
	output div_sts_t          sts,
	output logic [DIV_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FREQ_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [FREQ_W-1:0] div_q;
	logic [FREQ_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? FREQ_W'(trial - {1'b0, div_q}) : trial[FREQ_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

@@ src/freq_table_interpolator.sv @@
// Top level: frequency point table with nearest search and S11 interpolation.
// Clear, append and no-operation items go from the idle state to the finish state and on
// to the output register. A query scans the table, picks the pair, then works out the two
// S11 parts in turn (one shared multiplier, one 51-step serial divider).
// The scan reads the frequency memory one entry per cycle; only one item is in work.
// Reset clears the point count and the running minimum and maximum; memories are not cleared.
module freq_table_interpolator
	import fti_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [31:0]        frequency,
	input  logic signed [15:0] s11_re,
	input  logic signed [15:0] s11_im,
	input  logic signed [15:0] s21_re,
	input  logic signed [15:0] s21_im,
	input  logic signed [15:0] s12_re,
	input  logic signed [15:0] s12_im,
	input  logic signed [15:0] s22_re,
	input  logic signed [15:0] s22_im,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_s11_re,
	output logic signed [15:0] out_s11_im,
	output logic signed [15:0] out_s21_re,
	output logic signed [15:0] out_s21_im,
	output logic signed [15:0] out_s12_re,
	output logic signed [15:0] out_s12_im,
	output logic signed [15:0] out_s22_re,
	output logic signed [15:0] out_s22_im,
	output logic [7:0]         nearest_index,
	output logic               table_empty,
	output logic [31:0]        lowest_freq,
	output logic [31:0]        highest_freq
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;

	// Saturate a wide signed sum to the Q4.12 range.
	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [DIV_W+1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > (DIV_W+2)'(32767)) begin
			r = 16'sh7FFF;
		end else if (v < -(DIV_W+2)'(32768)) begin
			r = -16'sh8000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic              acc;
	logic              out_take;
	logic              out_load;
	logic              out_valid_q;
	logic [CW-1:0]     count_q;
	logic [FREQ_W-1:0] min_q;
	logic [FREQ_W-1:0] max_q;
	logic [1:0]        act_q;
	logic [FREQ_W-1:0] freq_q;

	// Memory ports.
	logic               we;
	logic [AW-1:0]      raddr;
	logic [FREQ_W-1:0]  rd_freq;
	logic [POINT_W-1:0] rd_val;
	logic [POINT_W-1:0] wr_val;

	// Scan.
	logic [CW-1:0]     scan_q;
	logic              pend_q;
	logic [AW-1:0]     pend_idx_q;
	logic [FREQ_W-1:0] best_d_q;
	logic [AW-1:0]     best_idx_q;
	logic [FREQ_W-1:0] best_f_q;
	logic [FREQ_W-1:0] cur_d;

	// Pair selection.
	logic          lo_ok;
	logic          hi_ok;
	logic          pair_q;
	logic          lower_q;
	logic [AW-1:0] other_q;

	// Interpolation.
	logic [FREQ_W-1:0]          fa;
	logic [FREQ_W-1:0]          fb;
	logic [2*VAL_W-1:0]         va_c;
	logic [2*VAL_W-1:0]         vb_c;
	logic signed [FREQ_W:0]     den_c;
	logic signed [FREQ_W:0]     num_c;
	logic signed [FREQ_W:0]     num_q;
	logic signed [FREQ_W:0]     den_q;
	logic [2*VAL_W-1:0]         va_q;
	logic [2*VAL_W-1:0]         vb_q;
	logic                       part_q;
	logic signed [VAL_W-1:0]    va_part;
	logic signed [VAL_W-1:0]    vb_part;
	logic signed [VAL_W:0]      dv;
	logic signed [FREQ_W+VAL_W+1:0] p_q;
	logic [FREQ_W+VAL_W+1:0]    abs_p;
	logic [FREQ_W:0]            abs_den33;
	logic [FREQ_W-1:0]          abs_den;
	logic                       neg_q;
	logic [DIV_W-1:0]           dividend;
	div_ctl_t                   div_ctl;
	div_sts_t                   div_sts;
	logic [DIV_W-1:0]           quotient;
	logic signed [DIV_W+1:0]    lerp_sum;
	logic signed [VAL_W-1:0]    lerp_res;

	// Result assembly and output register.
	logic signed [VAL_W-1:0] res_q [8];
	logic [AW-1:0]           nidx_q;
	logic signed [VAL_W-1:0] out_q [8];
	logic [7:0]              out_nidx_q;
	logic                    out_empty_q;
	logic [FREQ_W-1:0]       out_min_q;
	logic [FREQ_W-1:0]       out_max_q;

	assign in_stall = state_q != ST_IDLE;
	assign acc      = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = state_q == ST_FINISH && (!out_valid_q || !out_stall);

	// An append that fits writes the memories in the cycle it is accepted.
	assign we     = acc && action == ACT_APPEND && count_q < CW'(MAX_POINTS);
	assign wr_val = {s22_im, s22_re, s12_im, s12_re, s21_im, s21_re, s11_im, s11_re};

	always_comb begin
		unique case (state_q)
			ST_SCAN: raddr = scan_q[AW-1:0];
			ST_PICK: raddr = best_idx_q;
			default: raddr = other_q;
		endcase
	end

	fti_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_POINTS)) u_freq_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (frequency),
		.raddr (raddr),
		.rdata (rd_freq)
	);

	fti_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_val_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_val),
		.raddr (raddr),
		.rdata (rd_val)
	);

	// Distance of the entry just read from the query frequency.
	assign cur_d = rd_freq > freq_q ? rd_freq - freq_q : freq_q - rd_freq;

	// Neighbor: below when the nearest point (index > 0) sits at or above the query, else above.
	assign lo_ok = best_f_q >= freq_q && best_idx_q != '0;
	assign hi_ok = {1'b0, best_idx_q} < count_q - 1'b1;

	// Order the pair by index: the other entry is the lower one when lower_q is set.
	assign fa    = lower_q ? rd_freq : best_f_q;
	assign fb    = lower_q ? best_f_q : rd_freq;
	assign va_c  = lower_q ? rd_val[2*VAL_W-1:0] : {res_q[1], res_q[0]};
	assign vb_c  = lower_q ? {res_q[1], res_q[0]} : rd_val[2*VAL_W-1:0];
	assign den_c = $signed({1'b0, fb}) - $signed({1'b0, fa});
	assign num_c = $signed({1'b0, freq_q}) - $signed({1'b0, fa});

	// Shared arithmetic: one multiplier and the serial divider serve both S11 parts.
	assign va_part   = part_q ? $signed(va_q[2*VAL_W-1:VAL_W]) : $signed(va_q[VAL_W-1:0]);
	assign vb_part   = part_q ? $signed(vb_q[2*VAL_W-1:VAL_W]) : $signed(vb_q[VAL_W-1:0]);
	assign dv        = (VAL_W+1)'(vb_part) - (VAL_W+1)'(va_part);
	assign abs_p     = p_q < 0 ? $unsigned(-p_q) : $unsigned(p_q);
	assign abs_den33 = den_q < 0 ? $unsigned(-den_q) : $unsigned(den_q);
	assign abs_den   = abs_den33[FREQ_W-1:0];
	assign dividend  = DIV_W'(abs_p) + DIV_W'(abs_den >> 1);
	assign div_ctl.start = state_q == ST_DIV_GO;

	fti_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.divisor  (abs_den),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// Round to nearest with ties away from zero: the sign is applied after the division.
	assign lerp_sum = (DIV_W+2)'(va_part) +
		(neg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient}));
	assign lerp_res = sat16(lerp_sum);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (action == ACT_QUERY && count_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (scan_q == count_q - 1'b1) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_PICK;
			ST_PICK:     state_d = ST_RD_OTHER;
			ST_RD_OTHER: state_d = pair_q ? ST_GOT_OTHER : ST_FINISH;
			ST_GOT_OTHER: state_d = den_c == '0 ? ST_FINISH : ST_MUL;
			ST_MUL:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					state_d = part_q ? ST_FINISH : ST_MUL;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			pend_q      <= 1'b0;
			part_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= state_q == ST_SCAN;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (acc && action == ACT_CLEAR) begin
				count_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
			end else if (we) begin
				count_q <= count_q + 1'b1;
				if (count_q == '0) begin
					min_q <= frequency;
					max_q <= frequency;
				end else begin
					if (frequency < min_q) begin
						min_q <= frequency;
					end
					if (frequency > max_q) begin
						max_q <= frequency;
					end
				end
			end
			if (acc) begin
				part_q <= 1'b0;
			end else if (state_q == ST_DIV_WAIT && div_sts.done) begin
				part_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q  <= action;
			freq_q <= frequency;
			scan_q <= '0;
			nidx_q <= '0;
			for (int j = 0; j < 8; j++) begin
				res_q[j] <= '0;
			end
		end
		if (state_q == ST_SCAN) begin
			scan_q     <= scan_q + 1'b1;
			pend_idx_q <= scan_q[AW-1:0];
		end
		// The first entry always takes the lead; later ones need a strictly smaller distance.
		if (pend_q && (pend_idx_q == '0 || cur_d < best_d_q)) begin
			best_d_q   <= cur_d;
			best_idx_q <= pend_idx_q;
			best_f_q   <= rd_freq;
		end
		if (state_q == ST_PICK) begin
			pair_q  <= lo_ok || hi_ok;
			lower_q <= lo_ok;
			other_q <= lo_ok ? best_idx_q - 1'b1 : best_idx_q + 1'b1;
			nidx_q  <= best_idx_q;
		end
		if (state_q == ST_RD_OTHER) begin
			for (int j = 0; j < 8; j++) begin
				res_q[j] <= $signed(rd_val[j*VAL_W +: VAL_W]);
			end
		end
		if (state_q == ST_GOT_OTHER) begin
			num_q <= num_c;
			den_q <= den_c;
			va_q  <= va_c;
			vb_q  <= vb_c;
			if (den_c == '0) begin
				res_q[0] <= $signed(va_c[VAL_W-1:0]);
				res_q[1] <= $signed(va_c[2*VAL_W-1:VAL_W]);
			end
		end
		if (state_q == ST_MUL) begin
			p_q <= num_q * dv;
		end
		if (state_q == ST_DIV_GO) begin
			neg_q <= (p_q < 0) != (den_q < 0);
		end
		if (state_q == ST_DIV_WAIT && div_sts.done) begin
			res_q[{2'b00, part_q}] <= lerp_res;
		end
		if (out_load) begin
			for (int j = 0; j < 8; j++) begin
				out_q[j] <= act_q == ACT_QUERY ? res_q[j] : '0;
			end
			out_nidx_q  <= act_q == ACT_QUERY ? 8'(nidx_q) : '0;
			out_empty_q <= count_q == '0;
			out_min_q   <= min_q;
			out_max_q   <= max_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_s11_re    = out_q[0];
	assign out_s11_im    = out_q[1];
	assign out_s21_re    = out_q[2];
	assign out_s21_im    = out_q[3];
	assign out_s12_re    = out_q[4];
	assign out_s12_im    = out_q[5];
	assign out_s22_re    = out_q[6];
	assign out_s22_im    = out_q[7];
	assign nearest_index = out_nidx_q;
	assign table_empty   = out_empty_q;
	assign lowest_freq   = out_min_q;
	assign highest_freq  = out_max_q;

endmodule

@@ tb/freq_table_interpolator_tb.sv @@
// Self-checking testbench for the frequency table interpolator.
`timescale 1ns / 1ps
module freq_table_interpolator_tb;
	import fti_pkg::*;

	// One input item as the driver presents it.
	typedef struct {
		action_t act;
		logic [31:0] freq;
		logic signed [15:0] v [8];
	} item_t;

	// One result item as the block returns it.
	typedef struct {
		logic signed [15:0] v [8];
		logic [7:0] idx;
		logic empty;
		logic [31:0] lo;
		logic [31:0] hi;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] action = ACT_NOP;
	logic [31:0] frequency = 0;
	logic signed [15:0] vals [8];
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] out_s11_re, out_s11_im, out_s21_re, out_s21_im;
	logic signed [15:0] out_s12_re, out_s12_im, out_s22_re, out_s22_im;
	logic [7:0] nearest_index;
	logic table_empty;
	logic [31:0] lowest_freq, highest_freq;

	initial for (int i = 0; i < 8; i++) vals[i] = 0;

	freq_table_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .frequency(frequency),
		.s11_re(vals[0]), .s11_im(vals[1]), .s21_re(vals[2]), .s21_im(vals[3]),
		.s12_re(vals[4]), .s12_im(vals[5]), .s22_re(vals[6]), .s22_im(vals[7]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_s11_re(out_s11_re), .out_s11_im(out_s11_im),
		.out_s21_re(out_s21_re), .out_s21_im(out_s21_im),
		.out_s12_re(out_s12_re), .out_s12_im(out_s12_im),
		.out_s22_re(out_s22_re), .out_s22_im(out_s22_im),
		.nearest_index(nearest_index), .table_empty(table_empty),
		.lowest_freq(lowest_freq), .highest_freq(highest_freq)
	);

	always #4 clk = ~clk;

	// The predictor keeps its own copy of the point table.
	logic [31:0] tbl_freq [256];
	logic signed [15:0] tbl_val [256][8];
	int unsigned tbl_count;
	logic [31:0] tbl_min, tbl_max;

	item_t pending_items[$];
	res_t expected_results[$];
	int mismatches = 0;
	int accepted = 0;
	bit stimulus_done = 0;
	bit quiet = 0;        // stretch with no idling on either side
	bit hold_sender = 0;  // sender waits for the table to drain

	function automatic logic signed [15:0] sat16(longint x);
		if (x > 32767) return 16'sd32767;
		if (x < -32768) return -16'sd32768;
		return x[15:0];
	endfunction

	// Linear step from va toward vb, the fraction num/den rounded half away from zero.
	function automatic logic signed [15:0] lerp(longint va, longint vb, longint num, longint den);
		longint p, q;
		bit neg;
		longint unsigned up, ud;
		p = num * (vb - va);
		neg = (p < 0) != (den < 0);
		up = p < 0 ? -p : p;
		ud = den < 0 ? -den : den;
		q = (up + ud / 2) / ud;
		return sat16(va + (neg ? -q : q));
	endfunction

	// Applies one item to the predictor's table and returns the expected result.
	function automatic res_t interpolate_point(item_t it);
		res_t r;
		int unsigned best, a, b;
		logic [31:0] bd, d;
		longint den, num;
		for (int j = 0; j < 8; j++) r.v[j] = 0;
		r.idx = 0;
		case (it.act)
			ACT_CLEAR: begin
				tbl_count = 0; tbl_min = 0; tbl_max = 0;
			end
			ACT_APPEND: begin
				if (tbl_count < 256) begin
					tbl_freq[tbl_count] = it.freq;
					for (int j = 0; j < 8; j++) tbl_val[tbl_count][j] = it.v[j];
					if (tbl_count == 0) begin
						tbl_min = it.freq; tbl_max = it.freq;
					end else begin
						if (it.freq < tbl_min) tbl_min = it.freq;
						if (it.freq > tbl_max) tbl_max = it.freq;
					end
					tbl_count++;
				end
			end
			ACT_QUERY: begin
				if (tbl_count > 0) begin
					best = 0;
					bd = tbl_freq[0] >= it.freq ? tbl_freq[0] - it.freq : it.freq - tbl_freq[0];
					for (int i = 1; i < tbl_count; i++) begin
						d = tbl_freq[i] >= it.freq ? tbl_freq[i] - it.freq : it.freq - tbl_freq[i];
						if (d < bd) begin
							bd = d; best = i;
						end
					end
					r.idx = best[7:0];
					for (int j = 2; j < 8; j++) r.v[j] = tbl_val[best][j];
					a = best; b = best;
					if (tbl_count > 1) begin
						if (tbl_freq[best] >= it.freq && best > 0) begin
							a = best - 1;
						end else if (best < tbl_count - 1) begin
							b = best + 1;
						end
					end
					den = longint'(tbl_freq[b]) - longint'(tbl_freq[a]);
					num = longint'(it.freq) - longint'(tbl_freq[a]);
					if (a == b || den == 0) begin
						r.v[0] = tbl_val[a][0]; r.v[1] = tbl_val[a][1];
					end else begin
						r.v[0] = lerp(tbl_val[a][0], tbl_val[b][0], num, den);
						r.v[1] = lerp(tbl_val[a][1], tbl_val[b][1], num, den);
					end
				end
			end
			default: ;
		endcase
		r.empty = tbl_count == 0;
		r.lo = tbl_min;
		r.hi = tbl_max;
		return r;
	endfunction

	// Driver: presents items from the queue, holding each until it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(interpolate_point(pending_items[0]));
				void'(pending_items.pop_front());
				accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_items.size() > 0 && !hold_sender
						&& (quiet || $urandom_range(99) >= 19)) begin
					in_valid <= 1;
					action <= pending_items[0].act;
					frequency <= pending_items[0].freq;
					for (int j = 0; j < 8; j++) vals[j] <= pending_items[0].v[j];
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		logic signed [15:0] got [8];
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{out_s11_re, out_s11_im, out_s21_re, out_s21_im,
					out_s12_re, out_s12_im, out_s22_re, out_s22_im};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Result with nothing expected");
				end else begin
					e = expected_results.pop_front();
					if (got != e.v || nearest_index != e.idx || table_empty != e.empty
							|| lowest_freq != e.lo || highest_freq != e.hi) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: expected vals %p idx %0d empty %0d lo %0d hi %0d",
								e.v, e.idx, e.empty, e.lo, e.hi);
							$display("          actual   vals %p idx %0d empty %0d lo %0d hi %0d",
								got, nearest_index, table_empty, lowest_freq, highest_freq);
						end
					end
				end
			end
			out_stall <= !quiet && $urandom_range(99) < 19;
		end
	end

	// Cycle counter: a hung block ends the run here.
	int unsigned cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic item_t make_item(action_t act, logic [31:0] f);
		item_t it;
		it.act = act;
		it.freq = f;
		for (int j = 0; j < 8; j++) it.v[j] = 16'($urandom);
		return it;
	endfunction

	task automatic add(action_t act, logic [31:0] f);
		pending_items.push_back(make_item(act, f));
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
	endtask

	initial begin
		item_t it;
		logic [31:0] f, step;
		int n;
		tbl_count = 0; tbl_min = 0; tbl_max = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// Directed: empty query, no-operation, extreme values, one point, equal frequencies.
		add(ACT_QUERY, 32'd1000);
		add(ACT_NOP, 32'hFFFF_FFFF);
		it = make_item(ACT_APPEND, 32'd1000);
		for (int j = 0; j < 8; j++) it.v[j] = j[0] ? 16'sh7FFF : -16'sh8000;
		pending_items.push_back(it);
		add(ACT_QUERY, 32'd0);
		add(ACT_QUERY, 32'hFFFF_FFFF);
		it = make_item(ACT_APPEND, 32'd2000);
		for (int j = 0; j < 8; j++) it.v[j] = j[0] ? -16'sh8000 : 16'sh7FFF;
		pending_items.push_back(it);
		add(ACT_APPEND, 32'd2000);
		add(ACT_QUERY, 32'd0);          // extrapolation below the first point, saturates
		add(ACT_QUERY, 32'd1500);       // tie between neighbors, lowest index wins
		add(ACT_QUERY, 32'd1333);
		add(ACT_QUERY, 32'd2000);       // exact hit on a point, paired with the one below
		add(ACT_QUERY, 32'hFFFF_FFFF);
		add(ACT_APPEND, 32'd500);       // out of order
		add(ACT_APPEND, 32'hFFFF_FFFF);
		add(ACT_APPEND, 32'd0);
		add(ACT_QUERY, 32'd700);
		add(ACT_QUERY, 32'h8000_0000);
		add(ACT_QUERY, 32'd1);
		add(ACT_CLEAR, 32'd0);
		add(ACT_QUERY, 32'd5);
		drain();

		// Fill the table past full so dropped appends and wide indexes are seen.
		quiet = 1;
		for (int i = 0; i < 260; i++) add(ACT_APPEND, i * 32'd1000 + $urandom_range(999));
		add(ACT_QUERY, 32'd255_500);
		add(ACT_QUERY, 32'd128_250);
		add(ACT_QUERY, 32'hFFFF_FFFF);
		drain();
		quiet = 0;

		// Random phase: mostly ascending tables, then queries, mostly near them, and no-ops.
		n = 0;
		while (n < 320) begin
			add(ACT_CLEAR, $urandom);
			f = $urandom_range(3) == 0 ? $urandom : $urandom_range(100000);
			step = $urandom_range(3) == 0 ? $urandom_range(32'h00FF_FFFF) : $urandom_range(2000);
			for (int i = $urandom_range(1, 12); i > 0; i--) begin
				add(ACT_APPEND, $urandom_range(9) == 0 ? $urandom : f);
				f = f + ($urandom_range(7) == 0 ? 0 : step);
				n++;
			end
			for (int i = $urandom_range(2, 10); i > 0; i--) begin
				case ($urandom_range(4))
					0: add(ACT_QUERY, $urandom);
					1: add(ACT_NOP, $urandom);
					default: add(ACT_QUERY, f - $urandom_range(step * 14 + 1));
				endcase
				n++;
			end
			if (n > 120 && n < 170) begin
				// Sender holds off until the block has returned everything.
				drain();
				hold_sender = 1;
				repeat (20) @(posedge clk);
				hold_sender = 0;
				quiet = 1;
			end else if (n >= 170 && n < 250) begin
				drain();
				quiet = 0;
			end
		end
		drain();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/fti_pkg.sv
src/fti_ram.sv
src/fti_divider.sv
src/freq_table_interpolator.sv
tb/freq_table_interpolator_tb.sv
